[src/fpba_pkg.sv]
// Shared types, codes and defaults for the fit policy block allocator.
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 16;
   localparam int SIZE_WIDTH_DEFAULT = 16;

   localparam int BLOCK_INDEX_WIDTH = 4;
   localparam int SIZE_VALUE_WIDTH  = 16;
   localparam int FIT_MODE_WIDTH    = 2;
   localparam int BLOCK_COUNT_WIDTH = 5;
   localparam int CSR_DATA_WIDTH    = 5;
   localparam int CSR_ADDR_WIDTH    = 1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [FIT_MODE_WIDTH-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_MODE_WIDTH-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_MODE_WIDTH-1:0] FIT_WORST = 2'd2;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_FIT_MODE    = 1'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_BLOCK_COUNT = 1'd1;

   localparam logic [BLOCK_COUNT_WIDTH-1:0] BLOCK_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic                         cmd;
      logic [BLOCK_INDEX_WIDTH-1:0] block_index;
      logic [SIZE_VALUE_WIDTH-1:0]  size_value;
   } req_type;

   typedef struct packed {
      logic                         granted;
      logic [BLOCK_INDEX_WIDTH-1:0] granted_block;
   } rsp_type;

endpackage

`default_nettype wire

[src/fit_policy_block_allocator_unit.sv]
// Top level of the fit policy block allocator: capacity memory and scan sequencer.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a memory of remaining capacities, one entry per block.
// A command is transferred when start is high and busy is low. A load command
// writes one capacity in that same cycle and leaves busy low, so another
// command may follow in the next cycle. An allocate command raises busy and
// scans the first block_count blocks (saturated to NUM_BLOCKS), reading one
// memory entry per cycle through the single synchronous read port. The chosen
// block is charged with the request size and the result is shown on rsp_item
// with rsp_valid high for exactly one cycle, in the cycle that busy drops.
// After its transfer, an allocate command passes through the scan and drain
// states to the finish state, or straight to finish when no block is searched.
// The next command may be transferred in the cycle that shows the result.
// The receiver cannot stall; each result must be taken when it is shown.
// Configuration writes on the csr port take effect at once; the user must make
// them while the block is idle, as the block does not enforce it.
// Synchronous reset returns the sequencer to idle and the registers to first
// fit over 16 blocks; capacities are not cleared and each block must be
// loaded before it is searched.
module fit_policy_block_allocator_unit #(
   parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEFAULT,
   parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire fpba_pkg::req_type                   req_item,
   output      logic                                rsp_valid,
   output      fpba_pkg::rsp_type                   rsp_item,
   input  wire logic                                csr_we,
   input  wire logic [fpba_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [fpba_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int CW    = (CNT_W > fpba_pkg::BLOCK_COUNT_WIDTH) ?
                          CNT_W : fpba_pkg::BLOCK_COUNT_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                                state_ff;
   logic [fpba_pkg::FIT_MODE_WIDTH-1:0]      fit_mode_ff;
   logic [fpba_pkg::BLOCK_COUNT_WIDTH-1:0]   block_count_ff;
   logic [SIZE_WIDTH-1:0]                    size_ff;
   logic [IDX_W-1:0]                         rd_addr_ff;
   logic [IDX_W-1:0]                         last_ff;
   logic                                     cmp_valid_ff;
   logic [IDX_W-1:0]                         cmp_idx_ff;
   logic                                     found_ff;
   logic [IDX_W-1:0]                         pick_ff;
   logic [SIZE_WIDTH-1:0]                    pick_cap_ff;
   logic                                     rsp_valid_ff;
   fpba_pkg::rsp_type                        rsp_item_ff;

   logic [SIZE_WIDTH-1:0]                    mem [NUM_BLOCKS];
   logic [SIZE_WIDTH-1:0]                    rd_data_ff;

   logic                                     accept;
   logic [SIZE_WIDTH-1:0]                    req_size;
   logic [CW-1:0]                            count_ext;
   logic [CW-1:0]                            limit;
   logic                                     load_in_range;
   logic                                     fits;
   logic                                     take;
   logic                                     mem_we;
   logic [IDX_W-1:0]                         mem_waddr;
   logic [SIZE_WIDTH-1:0]                    mem_wdata;

   assign accept        = start && (state_ff == ST_IDLE);
   assign req_size      = SIZE_WIDTH'(req_item.size_value);
   assign count_ext     = CW'(block_count_ff);
   assign limit         = (count_ext > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : count_ext;
   assign load_in_range = CW'(req_item.block_index) < CW'(NUM_BLOCKS);

   assign fits = rd_data_ff >= size_ff;

   always_comb begin
      take = 1'b0;
      if (cmp_valid_ff && fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else begin
            case (fit_mode_ff)
               fpba_pkg::FIT_BEST:  take = rd_data_ff < pick_cap_ff;
               fpba_pkg::FIT_WORST: take = rd_data_ff > pick_cap_ff;
               default:             take = 1'b0;
            endcase
         end
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pick_ff;
      mem_wdata = pick_cap_ff - size_ff;
      if (accept && (req_item.cmd == fpba_pkg::CMD_LOAD)) begin
         mem_we    = load_in_range;
         mem_waddr = IDX_W'(req_item.block_index);
         mem_wdata = req_size;
      end else if ((state_ff == ST_FINISH) && found_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fit_mode_ff    <= fpba_pkg::FIT_FIRST;
         block_count_ff <= fpba_pkg::BLOCK_COUNT_RESET;
         cmp_valid_ff   <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;

         if (csr_we) begin
            case (csr_addr)
               fpba_pkg::CSR_FIT_MODE: begin
                  fit_mode_ff <= csr_wdata[fpba_pkg::FIT_MODE_WIDTH-1:0];
               end
               fpba_pkg::CSR_BLOCK_COUNT: begin
                  block_count_ff <= csr_wdata[fpba_pkg::BLOCK_COUNT_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end

         if (take) begin
            found_ff    <= 1'b1;
            pick_ff     <= cmp_idx_ff;
            pick_cap_ff <= rd_data_ff;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_item.cmd == fpba_pkg::CMD_ALLOC)) begin
                  size_ff    <= req_size;
                  found_ff   <= 1'b0;
                  rd_addr_ff <= '0;
                  last_ff    <= IDX_W'(limit - CW'(1));
                  state_ff   <= (limit == '0) ? ST_FINISH : ST_SCAN;
               end
            end
            ST_SCAN: begin
               cmp_valid_ff <= 1'b1;
               cmp_idx_ff   <= rd_addr_ff;
               rd_addr_ff   <= rd_addr_ff + IDX_W'(1);
               if (rd_addr_ff == last_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               rsp_valid_ff              <= 1'b1;
               rsp_item_ff.granted       <= found_ff;
               rsp_item_ff.granted_block <= found_ff ?
                  fpba_pkg::BLOCK_INDEX_WIDTH'(pick_ff) : '0;
               state_ff                  <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

[src/fpba_checker.sv]
// Port checker for the fit policy block allocator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module fpba_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire fpba_pkg::req_type                   req_item,
   input wire logic                                rsp_valid,
   input wire fpba_pkg::rsp_type                   rsp_item
);

   // A load transfer completes in its own cycle and leaves the block free.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.cmd == fpba_pkg::CMD_LOAD)) |=> !busy)
      else $error("busy rose after a load transfer");

   // An allocate transfer always raises busy, though it skips the scan when no block is searched.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.cmd == fpba_pkg::CMD_ALLOC)) |=> busy)
      else $error("busy did not rise after an allocate transfer");

   // A result only closes an allocate command that kept busy high in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result shown outside the end of a scan");

   // Each scan yields a single one-cycle result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A refused request reports block zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.granted) |-> (rsp_item.granted_block == '0))
      else $error("refused request reports a nonzero block");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire
